// File: rtl/core/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// Types and constants shared by the instruction step core files.
// ----------------------------------------------------------------------------
package sci_pkg;

	localparam int unsigned INSTR_W = 48;
	localparam int unsigned XLEN    = 32;
	localparam int unsigned PC_W    = 12;
	localparam int unsigned RF_AW   = 4;

	typedef logic [XLEN-1:0] word_t;
	typedef logic [PC_W-1:0] pc_t;
	typedef logic [RF_AW-1:0] rf_idx_t;

	typedef enum logic [7:0] {
		OP_ADD  = 8'd0,  OP_SUB  = 8'd1,  OP_MAC  = 8'd2,  OP_AND  = 8'd3,
		OP_OR   = 8'd4,  OP_XOR  = 8'd5,  OP_SLL  = 8'd6,  OP_SRA  = 8'd7,
		OP_SRL  = 8'd8,  OP_BEQ  = 8'd9,  OP_BNE  = 8'd10, OP_BLT  = 8'd11,
		OP_BGT  = 8'd12, OP_BLE  = 8'd13, OP_BGE  = 8'd14, OP_JAL  = 8'd15,
		OP_LW   = 8'd16, OP_SW   = 8'd17, OP_RETI = 8'd18, OP_IN   = 8'd19,
		OP_OUT  = 8'd20, OP_HALT = 8'd21
	} opcode_t;

	typedef enum logic [1:0] {
		IO_NONE  = 2'd0,
		IO_READ  = 2'd1,
		IO_WRITE = 2'd2
	} io_access_t;

	// fixed io register numbers
	localparam int unsigned IO_IRQ0EN   = 0;
	localparam int unsigned IO_IRQ1EN   = 1;
	localparam int unsigned IO_IRQ2EN   = 2;
	localparam int unsigned IO_IRQ0ST   = 3;
	localparam int unsigned IO_IRQ1ST   = 4;
	localparam int unsigned IO_IRQ2ST   = 5;
	localparam int unsigned IO_IRQHDL   = 6;
	localparam int unsigned IO_IRQRET   = 7;
	localparam int unsigned IO_CLKS     = 8;
	localparam int unsigned IO_TMREN    = 11;
	localparam int unsigned IO_TMRCUR   = 12;
	localparam int unsigned IO_TMRMAX   = 13;
	localparam int unsigned IO_MONADDR  = 20;
	localparam int unsigned IO_MONDATA  = 21;
	localparam int unsigned IO_MONCMD   = 22;

	localparam word_t SEXT_HI  = 32'hFFFF_F000;
	localparam word_t PC_LIMIT = 32'h0000_1000;

	function automatic word_t sext12(input logic [11:0] v);
		return v[11] ? (SEXT_HI | {20'd0, v}) : {20'd0, v};
	endfunction

endpackage

// File: rtl/core/sci_instr_if.sv
// ----------------------------------------------------------------------------
// sci_instr_if
// Instruction channel: one instruction word and the irq2 pulse per transfer.
// ----------------------------------------------------------------------------
interface sci_instr_if;
	logic        valid;
	logic        ready;
	logic [47:0] instr_word;
	logic        irq2_pulse;

	modport source (output valid, output instr_word, output irq2_pulse, input ready);
	modport sink   (input valid, input instr_word, input irq2_pulse, output ready);
endinterface

// File: rtl/core/sci_result_if.sv
// ----------------------------------------------------------------------------
// sci_result_if
// Result channel: next fetch address, status, io access and pixel write.
// ----------------------------------------------------------------------------
interface sci_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] fetch_pc;
	logic        halted;
	logic        error_flag;
	logic [1:0]  io_access;
	logic [4:0]  io_index;
	logic [31:0] io_data;
	logic [31:0] cycle_count;
	logic        pixel_write;
	logic [15:0] pixel_addr;
	logic [7:0]  pixel_value;

	modport source (output valid, output fetch_pc, output halted, output error_flag,
		output io_access, output io_index, output io_data, output cycle_count,
		output pixel_write, output pixel_addr, output pixel_value, input ready);
	modport sink (input valid, input fetch_pc, input halted, input error_flag,
		input io_access, input io_index, input io_data, input cycle_count,
		input pixel_write, input pixel_addr, input pixel_value, output ready);
endinterface

// File: rtl/core/simp_core_instruction_step_top.sv
// ----------------------------------------------------------------------------
// simp_core_instruction_step_top
// Executes one instruction per transfer and reports fetch address and io.
// ----------------------------------------------------------------------------
// Each instruction runs through the steps ST_IDLE, ST_RD2, ST_EX and ST_WB:
// register file reads on the transfer step and in ST_RD2 (two read ports per
// cycle, four operands), the data memory read and multiply in ST_EX, and write
// back and the io block tick in ST_WB, which waits while a result is pending.
// After reset the data memory is cleared one word per cycle, and no instruction
// is taken until the clear is done. A finished result waits in an output
// register; the next instruction is taken once the sequencer is back at its
// first step, even while that result is pending. DATA_DEPTH must be a power of two.
module simp_core_instruction_step_top #(
	parameter int unsigned DATA_DEPTH   = 4096,
	parameter int unsigned IO_REG_COUNT = 23
) (
	input  logic clk,
	input  logic arst_n,
	sci_instr_if.sink    in_ch,
	sci_result_if.source out_ch
);
	import sci_pkg::*;

	localparam int unsigned DAW = $clog2(DATA_DEPTH);

	typedef enum logic [1:0] {ST_IDLE, ST_RD2, ST_EX, ST_WB} state_t;

	state_t state_q;
	logic [47:0] instr_q;
	logic        irq2_q;
	word_t a_q, b_q, c_q, d_q, prod_q;
	logic [DAW-1:0] daddr_q;
	logic [15:0] rf_vld_q;
	logic        clr_q;
	logic [DAW-1:0] clr_addr_q;

	word_t io_q [IO_REG_COUNT];
	pc_t  pc_q;
	logic insvc_q, stopped_q, halt_q, err_q;

	logic out_vld_q;
	pc_t  o_pc_q;
	logic o_halt_q, o_err_q, o_pix_q;
	logic [1:0] o_acc_q;
	logic [4:0] o_idx_q;
	word_t o_data_q, o_cyc_q;
	logic [15:0] o_paddr_q;
	logic [7:0]  o_pval_q;

	// register file, two copies for two reads per cycle
	rf_idx_t rf_ra0, rf_ra1;
	word_t   rf_rd0, rf_rd1, rf_wdata, dm_rdata, dm_wdata;
	logic    rf_we, dm_we;
	logic [DAW-1:0] dm_addr_w;
	logic [DAW-1:0] dm_raddr;

	logic commit;
	assign commit = (state_q == ST_WB) && (!out_vld_q || out_ch.ready);

	always_comb begin
		if (state_q == ST_IDLE) begin
			rf_ra0 = in_ch.instr_word[35:32];
			rf_ra1 = in_ch.instr_word[31:28];
		end else begin
			rf_ra0 = instr_q[27:24];
			rf_ra1 = instr_q[39:36];
		end
	end

	sci_ram #(.WIDTH(XLEN), .DEPTH(16)) u_rf0 (
		.clk(clk), .we(rf_we), .waddr(instr_q[39:36]), .wdata(rf_wdata),
		.raddr(rf_ra0), .rdata(rf_rd0)
	);
	sci_ram #(.WIDTH(XLEN), .DEPTH(16)) u_rf1 (
		.clk(clk), .we(rf_we), .waddr(instr_q[39:36]), .wdata(rf_wdata),
		.raddr(rf_ra1), .rdata(rf_rd1)
	);
	sci_ram #(.WIDTH(XLEN), .DEPTH(DATA_DEPTH)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_addr_w), .wdata(dm_wdata),
		.raddr(dm_raddr), .rdata(dm_rdata)
	);

	// r0 reads zero, r1/r2 hold the immediates, unwritten entries read zero
	function automatic word_t rf_sel(input rf_idx_t i, input word_t ram,
		input logic [47:0] iw, input logic [15:0] vld);
		word_t v;
		v = ram;
		if (i == 4'd0) v = '0;
		else if (i == 4'd1) v = sext12(iw[23:12]);
		else if (i == 4'd2) v = sext12(iw[11:0]);
		else if (!vld[i]) v = '0;
		return v;
	endfunction

	// write-back and io tick
	opcode_t op;
	word_t   idx, res, nxt, io_val, irqv;
	logic    rf_wr, taken, halt_n, err_n, insvc_n, pix_n;
	word_t   io_n [IO_REG_COUNT];
	pc_t     pc_n;
	io_access_t acc_n;
	logic [15:0] paddr_n;
	logic [7:0]  pval_n;

	always_comb begin
		op      = opcode_t'(instr_q[47:40]);
		idx     = a_q + b_q;
		res     = '0;
		rf_wr   = 1'b0;
		taken   = 1'b0;
		nxt     = {20'd0, pc_q} + 32'd1;
		halt_n  = halt_q;
		err_n   = err_q;
		insvc_n = insvc_q;
		acc_n   = IO_NONE;
		io_val  = '0;
		pix_n   = 1'b0;
		paddr_n = '0;
		pval_n  = '0;
		dm_wdata = c_q + d_q;
		for (int i = 0; i < IO_REG_COUNT; i++) io_n[i] = io_q[i];
		io_val = (idx < IO_REG_COUNT) ? io_q[idx[4:0]] : '0;
		unique case (op)
			OP_ADD:  begin res = a_q + b_q + c_q; rf_wr = 1'b1; end
			OP_SUB:  begin res = a_q - b_q - c_q; rf_wr = 1'b1; end
			OP_MAC:  begin res = prod_q + c_q; rf_wr = 1'b1; end
			OP_AND:  begin res = a_q & b_q & c_q; rf_wr = 1'b1; end
			OP_OR:   begin res = a_q | b_q | c_q; rf_wr = 1'b1; end
			OP_XOR:  begin res = a_q ^ b_q ^ c_q; rf_wr = 1'b1; end
			OP_SLL:  begin res = (b_q >= 32'd32) ? '0 : (a_q << b_q[4:0]); rf_wr = 1'b1; end
			OP_SRA:  begin
				res = word_t'($signed(a_q) >>> ((b_q >= 32'd32) ? 5'd31 : b_q[4:0]));
				rf_wr = 1'b1;
			end
			OP_SRL:  begin res = (b_q >= 32'd32) ? '0 : (a_q >> b_q[4:0]); rf_wr = 1'b1; end
			OP_BEQ:  taken = (a_q == b_q);
			OP_BNE:  taken = (a_q != b_q);
			OP_BLT:  taken = (a_q < b_q);
			OP_BGT:  taken = (a_q > b_q);
			OP_BLE:  taken = (a_q <= b_q);
			OP_BGE:  taken = (a_q >= b_q);
			OP_JAL:  begin res = {20'd0, pc_q} + 32'd1; rf_wr = 1'b1; taken = 1'b1; end
			OP_LW:   begin res = dm_rdata + c_q; rf_wr = 1'b1; end
			OP_SW:   ;
			OP_RETI: begin nxt = io_q[IO_IRQRET]; insvc_n = 1'b0; end
			OP_IN:   begin res = io_val; rf_wr = 1'b1; acc_n = IO_READ; end
			OP_OUT:  begin
				acc_n = IO_WRITE;
				io_val = c_q;
				for (int i = 0; i < IO_REG_COUNT; i++)
					if (idx == i) io_n[i] = c_q;
			end
			OP_HALT: halt_n = 1'b1;
			default: ;
		endcase
		if (taken) nxt = {20'd0, c_q[11:0]};

		if (io_n[IO_TMREN][0]) begin
			if (io_n[IO_TMRCUR] == io_n[IO_TMRMAX]) begin
				io_n[IO_IRQ0ST] = 32'd1;
				io_n[IO_TMRCUR] = '0;
			end else begin
				io_n[IO_TMRCUR] = io_n[IO_TMRCUR] + 32'd1;
			end
		end
		if (io_n[IO_MONCMD] != '0) begin
			pix_n   = 1'b1;
			paddr_n = io_n[IO_MONADDR][15:0];
			pval_n  = io_n[IO_MONDATA][7:0];
			io_n[IO_MONCMD] = '0;
		end
		io_n[IO_IRQ2ST] = {31'd0, irq2_q};
		io_n[IO_CLKS]   = io_n[IO_CLKS] + 32'd1;

		pc_n = nxt[11:0];
		irqv = (io_n[IO_IRQ0EN] & io_n[IO_IRQ0ST]) | (io_n[IO_IRQ1EN] & io_n[IO_IRQ1ST]) |
			(io_n[IO_IRQ2EN] & io_n[IO_IRQ2ST]);
		if (nxt >= PC_LIMIT) begin
			err_n = 1'b1;
		end else if (!halt_n && irqv != '0 && !insvc_n) begin
			insvc_n = 1'b1;
			io_n[IO_IRQRET] = {20'd0, pc_n};
			pc_n = io_n[IO_IRQHDL][11:0];
			if (io_n[IO_IRQHDL] >= PC_LIMIT) err_n = 1'b1;
		end
	end

	// data read address follows the operands so the word is ready in write-back
	assign dm_raddr  = idx[DAW-1:0];
	assign rf_wdata  = res;
	assign rf_we     = commit && !stopped_q && rf_wr && (instr_q[39:36] > 4'd2);
	assign dm_we     = clr_q || (commit && !stopped_q && op == OP_SW);
	assign dm_addr_w = clr_q ? clr_addr_q : daddr_q;

	assign in_ch.ready = (state_q == ST_IDLE) && !clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			rf_vld_q   <= '0;
			pc_q       <= '0;
			insvc_q    <= 1'b0;
			stopped_q  <= 1'b0;
			halt_q     <= 1'b0;
			err_q      <= 1'b0;
			out_vld_q  <= 1'b0;
			for (int i = 0; i < IO_REG_COUNT; i++) io_q[i] <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == DAW'(DATA_DEPTH - 1)) clr_q <= 1'b0;
			end
			if (out_vld_q && out_ch.ready) out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid && in_ch.ready) state_q <= ST_RD2;
				ST_RD2:  state_q <= ST_EX;
				ST_EX:   state_q <= ST_WB;
				ST_WB: begin
					if (commit) begin
						state_q   <= ST_IDLE;
						out_vld_q <= 1'b1;
						if (stopped_q) begin
							o_pc_q    <= pc_q;
							o_halt_q  <= halt_q;
							o_err_q   <= err_q;
							o_acc_q   <= IO_NONE;
							o_idx_q   <= '0;
							o_data_q  <= '0;
							o_cyc_q   <= io_q[IO_CLKS];
							o_pix_q   <= 1'b0;
							o_paddr_q <= '0;
							o_pval_q  <= '0;
						end else begin
							if (rf_we) rf_vld_q[instr_q[39:36]] <= 1'b1;
							for (int i = 0; i < IO_REG_COUNT; i++) io_q[i] <= io_n[i];
							pc_q      <= pc_n;
							insvc_q   <= insvc_n;
							halt_q    <= halt_n;
							err_q     <= err_n;
							stopped_q <= halt_n || err_n;
							o_pc_q    <= pc_n;
							o_halt_q  <= halt_n;
							o_err_q   <= err_n;
							o_acc_q   <= acc_n;
							o_idx_q   <= (acc_n == IO_NONE) ? 5'd0 : idx[4:0];
							o_data_q  <= (acc_n == IO_NONE) ? '0 : io_val;
							o_cyc_q   <= io_q[IO_CLKS];
							o_pix_q   <= pix_n;
							o_paddr_q <= paddr_n;
							o_pval_q  <= pval_n;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand capture, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			instr_q <= in_ch.instr_word;
			irq2_q  <= in_ch.irq2_pulse;
		end
		if (state_q == ST_RD2) begin
			a_q <= rf_sel(instr_q[35:32], rf_rd0, instr_q, rf_vld_q);
			b_q <= rf_sel(instr_q[31:28], rf_rd1, instr_q, rf_vld_q);
		end
		if (state_q == ST_EX) begin
			c_q     <= rf_sel(instr_q[27:24], rf_rd0, instr_q, rf_vld_q);
			d_q     <= rf_sel(instr_q[39:36], rf_rd1, instr_q, rf_vld_q);
			daddr_q <= idx[DAW-1:0];
			prod_q  <= a_q * b_q;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.fetch_pc    = o_pc_q;
	assign out_ch.halted      = o_halt_q;
	assign out_ch.error_flag  = o_err_q;
	assign out_ch.io_access   = o_acc_q;
	assign out_ch.io_index    = o_idx_q;
	assign out_ch.io_data     = o_data_q;
	assign out_ch.cycle_count = o_cyc_q;
	assign out_ch.pixel_write = o_pix_q;
	assign out_ch.pixel_addr  = o_paddr_q;
	assign out_ch.pixel_value = o_pval_q;
endmodule

// File: rtl/core/sci_ram.sv
// ----------------------------------------------------------------------------
// sci_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sci_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/sci_checker.sv
// ----------------------------------------------------------------------------
// sci_checker
// Port-level checks on the instruction step core, bound to the top level.
// ----------------------------------------------------------------------------
module sci_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       halted,
	input logic [1:0] io_access
);
	import sci_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("instruction taken during execution");

	a_halt_no_io: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halted |-> io_access == IO_NONE)
		else $error("io access reported after halt");

	a_io_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> io_access == IO_NONE || io_access == IO_READ || io_access == IO_WRITE)
		else $error("bad io access code");
endmodule

bind simp_core_instruction_step_top sci_checker u_sci_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.halted(out_ch.halted), .io_access(out_ch.io_access)
);
